// ----- hw/rtl/ultrasound_arrival_timer_assert.svh -----
// Assertion macros used by the ultrasound arrival timer checker.
`ifndef ULTRASOUND_ARRIVAL_TIMER_ASSERT_SVH
`define ULTRASOUND_ARRIVAL_TIMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UAT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uat assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define UAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uat assertion failed");

`endif

// ----- hw/rtl/uat_pkg.sv -----
// Types and constants for the ultrasound arrival timer.
package uat_pkg;

  typedef logic [1:0] action_t;
  typedef logic [1:0] mode_t;
  typedef logic [2:0] status_t;
  typedef logic [2:0] cfg_index_t;

  localparam action_t ACT_ARM  = 2'd0;
  localparam action_t ACT_PKT  = 2'd1;
  localparam action_t ACT_POLL = 2'd2;

  localparam mode_t MODE_ONE  = 2'd0;
  localparam mode_t MODE_TWO  = 2'd1;
  localparam mode_t MODE_XOR  = 2'd2;
  localparam mode_t MODE_OMNI = 2'd3;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_ONE_FIRST  = 3'd1;
  localparam status_t ST_TWO_FIRST  = 3'd2;
  localparam status_t ST_ONE_MISSED = 3'd3;
  localparam status_t ST_TWO_MISSED = 3'd4;
  localparam status_t ST_TIMEOUT    = 3'd5;

  localparam logic KIND_RF = 1'b0;
  localparam logic KIND_US = 1'b1;

  localparam cfg_index_t CFG_MODE   = 3'd0;
  localparam cfg_index_t CFG_FILTER = 3'd1;
  localparam cfg_index_t CFG_MAXIT  = 3'd2;
  localparam cfg_index_t CFG_FLAG0  = 3'd3;
  localparam cfg_index_t CFG_FLAG1  = 3'd4;

  localparam int CFG_DATA_W = 16;

  localparam logic signed [7:0] NODE_ANY = -8'sd1;
  localparam logic [15:0] MAXIT_RESET = 16'd1000;

endpackage

// ----- hw/rtl/ultrasound_arrival_timer.sv -----
// Acoustic ranging capture: packet match, pin polling and result timing.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   in_     | input     | in_valid / in_stall  | action, now_us, head bytes, sender, pins
//   out_    | output    | out_valid / out_stall| kind, node_id, tdoa_us, orient_us, status
//   cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each request is held in the input register and is resolved from there into the result
// register, so a new request can be taken every cycle while in_stall is low.
// A result is registered once its request leaves the input register; a request that gives no
// result simply drains. in_stall rises only when the result register is full and stalled.
// Synchronous active-low reset clears control state and loads register defaults.
module ultrasound_arrival_timer import uat_pkg::*; #(
  parameter int TIME_WIDTH  = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_action,
  input  logic [31:0]             in_now_us,
  input  logic [7:0]              in_head_zero,
  input  logic [7:0]              in_head_one,
  input  logic signed [7:0]       in_sender,
  input  logic                    in_pin_one,
  input  logic                    in_pin_two,
  input  logic                    in_pin_logic,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_kind,
  output logic signed [7:0]       out_node_id,
  output logic [31:0]             out_tdoa_us,
  output logic [31:0]             out_orient_us,
  output logic [2:0]              out_status,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int LW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [LW-1:0] CMAX = LW'({COUNT_WIDTH{1'b1}});

  typedef logic [TIME_WIDTH-1:0]  time_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  // Configuration registers.
  mode_t             mode_r;
  logic signed [7:0] filt_r;
  logic [15:0]       maxit_r;
  logic [7:0]        fb0_r;
  logic [7:0]        fb1_r;

  // Input register.
  logic              s1_valid_r;
  action_t           s1_action_r;
  time_t             s1_now_r;
  logic [7:0]        s1_h0_r;
  logic [7:0]        s1_h1_r;
  logic signed [7:0] s1_sender_r;
  logic              s1_p1_r;
  logic              s1_p2_r;
  logic              s1_pl_r;

  // Measurement state.
  logic              armed_r, armed_nxt;
  logic              meas_r, meas_nxt;
  logic              wait_r, wait_nxt;
  logic              two_r, two_nxt;
  time_t             start_r, start_nxt;
  time_t             cap_r, cap_nxt;
  count_t            poll_r, poll_nxt;
  logic signed [7:0] target_r, target_nxt;

  // Result register.
  logic              out_valid_r;
  logic              out_kind_r;
  logic signed [7:0] out_node_r;
  time_t             out_tdoa_r;
  time_t             out_orient_r;
  status_t           out_status_r;

  logic              out_free;
  logic              step;
  logic              in_accept;

  logic [LW-1:0]     lim;
  count_t            poll_inc;
  logic              poll_done;
  logic              poll_done_inc;
  logic              hit;
  time_t             ec_cap;
  logic              ec_two;
  time_t             ec_tdoa;
  time_t             ec_gap;
  logic              ec_f;
  logic              ec_s;
  logic              ec_done;
  status_t           ec_status;
  time_t             now_tdoa;

  logic              res_v;
  logic              res_kind;
  logic signed [7:0] res_node;
  time_t             res_tdoa;
  time_t             res_orient;
  status_t           res_status;
  logic              fin;

  assign out_free  = !out_valid_r || !out_stall;
  assign step      = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign lim = (LW'(maxit_r) > CMAX) ? CMAX : LW'(maxit_r);
  assign poll_inc      = poll_r + 1'b1;
  assign poll_done     = LW'(poll_r) >= lim;
  assign poll_done_inc = LW'(poll_inc) >= lim;

  // A first pin hit in two-sensor mode runs the gap test on the same sample.
  assign hit = meas_r && !wait_r && !poll_done && (mode_r == MODE_TWO) &&
               (s1_p1_r || s1_p2_r);
  assign ec_cap  = hit ? s1_now_r : cap_r;
  assign ec_two  = hit ? !s1_p1_r : two_r;
  assign ec_tdoa = ec_cap - start_r;
  assign ec_gap  = s1_now_r - ec_cap;
  assign ec_f    = ec_two ? s1_p2_r : s1_p1_r;
  assign ec_s    = ec_two ? s1_p1_r : s1_p2_r;
  assign ec_done = (mode_r == MODE_XOR) ? !s1_pl_r : !(ec_f && !ec_s);
  assign now_tdoa = s1_now_r - start_r;

  always_comb begin
    if (mode_r == MODE_XOR) begin
      ec_status = ST_OK;
    end else if (ec_two) begin
      ec_status = ec_f ? ST_TWO_FIRST : ST_TWO_MISSED;
    end else begin
      ec_status = ec_f ? ST_ONE_FIRST : ST_ONE_MISSED;
    end
  end

  always_comb begin
    armed_nxt  = armed_r;
    meas_nxt   = meas_r;
    wait_nxt   = wait_r;
    two_nxt    = two_r;
    start_nxt  = start_r;
    cap_nxt    = cap_r;
    poll_nxt   = poll_r;
    target_nxt = target_r;
    res_v      = 1'b0;
    res_kind   = KIND_US;
    res_node   = target_r;
    res_tdoa   = '0;
    res_orient = '0;
    res_status = ST_OK;
    fin        = 1'b0;
    if (step) begin
      case (s1_action_r)
        ACT_ARM: begin
          armed_nxt = 1'b1;
        end
        ACT_PKT: begin
          if (armed_r && !meas_r && s1_h0_r == fb0_r && s1_h1_r == fb1_r) begin
            if (filt_r == NODE_ANY || filt_r == s1_sender_r) begin
              meas_nxt   = 1'b1;
              wait_nxt   = 1'b0;
              two_nxt    = 1'b0;
              start_nxt  = s1_now_r;
              cap_nxt    = s1_now_r;
              poll_nxt   = '0;
              target_nxt = s1_sender_r;
            end
            res_v    = 1'b1;
            res_kind = KIND_RF;
            res_node = s1_sender_r;
          end
        end
        ACT_POLL: begin
          if (meas_r) begin
            if (wait_r) begin
              if (ec_done) begin
                fin        = 1'b1;
                res_tdoa   = ec_tdoa;
                res_orient = ec_gap;
                res_status = ec_status;
              end
            end else if (poll_done) begin
              fin        = 1'b1;
              res_status = ST_TIMEOUT;
            end else begin
              poll_nxt = poll_inc;
              case (mode_r)
                MODE_ONE: begin
                  if (s1_p1_r) begin
                    fin      = 1'b1;
                    res_tdoa = now_tdoa;
                  end else if (poll_done_inc) begin
                    fin        = 1'b1;
                    res_status = ST_TIMEOUT;
                  end
                end
                MODE_TWO: begin
                  if (hit) begin
                    two_nxt  = ec_two;
                    cap_nxt  = s1_now_r;
                    wait_nxt = 1'b1;
                    if (ec_done) begin
                      fin        = 1'b1;
                      res_tdoa   = ec_tdoa;
                      res_orient = ec_gap;
                      res_status = ec_status;
                    end
                  end else if (poll_done_inc) begin
                    fin        = 1'b1;
                    res_status = ST_TIMEOUT;
                  end
                end
                MODE_XOR: begin
                  if (s1_pl_r) begin
                    cap_nxt  = s1_now_r;
                    wait_nxt = 1'b1;
                  end else if (poll_done_inc) begin
                    fin        = 1'b1;
                    res_status = ST_TIMEOUT;
                  end
                end
                default: begin
                  if (s1_pl_r) begin
                    fin      = 1'b1;
                    res_tdoa = now_tdoa;
                  end else if (poll_done_inc) begin
                    fin        = 1'b1;
                    res_status = ST_TIMEOUT;
                  end
                end
              endcase
            end
          end
        end
        default: begin
        end
      endcase
      // Any ultrasound result ends the shot.
      if (fin) begin
        res_v     = 1'b1;
        meas_nxt  = 1'b0;
        wait_nxt  = 1'b0;
        armed_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_ONE;
      filt_r  <= NODE_ANY;
      maxit_r <= MAXIT_RESET;
      fb0_r   <= '0;
      fb1_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:   mode_r  <= cfg_data[1:0];
        CFG_FILTER: filt_r  <= cfg_data[7:0];
        CFG_MAXIT:  maxit_r <= cfg_data[15:0];
        CFG_FLAG0:  fb0_r   <= cfg_data[7:0];
        CFG_FLAG1:  fb1_r   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (out_free) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action_r <= in_action;
      s1_now_r    <= TIME_WIDTH'(in_now_us);
      s1_h0_r     <= in_head_zero;
      s1_h1_r     <= in_head_one;
      s1_sender_r <= in_sender;
      s1_p1_r     <= in_pin_one;
      s1_p2_r     <= in_pin_two;
      s1_pl_r     <= in_pin_logic;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r  <= 1'b0;
      meas_r   <= 1'b0;
      wait_r   <= 1'b0;
      two_r    <= 1'b0;
      start_r  <= '0;
      cap_r    <= '0;
      poll_r   <= '0;
      target_r <= '0;
    end else begin
      armed_r  <= armed_nxt;
      meas_r   <= meas_nxt;
      wait_r   <= wait_nxt;
      two_r    <= two_nxt;
      start_r  <= start_nxt;
      cap_r    <= cap_nxt;
      poll_r   <= poll_nxt;
      target_r <= target_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (res_v) begin
      out_kind_r   <= res_kind;
      out_node_r   <= res_node;
      out_tdoa_r   <= res_tdoa;
      out_orient_r <= res_orient;
      out_status_r <= res_status;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_node_id   = out_node_r;
  assign out_tdoa_us   = 32'(out_tdoa_r);
  assign out_orient_us = 32'(out_orient_r);
  assign out_status    = out_status_r;

endmodule

// ----- hw/rtl/uat_checker.sv -----
// Port-level checker for the ultrasound arrival timer, with its bind.
`include "ultrasound_arrival_timer_assert.svh"

module uat_checker import uat_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_kind,
  input logic signed [7:0] out_node_id,
  input logic [31:0]       out_tdoa_us,
  input logic [31:0]       out_orient_us,
  input logic [2:0]        out_status
);

  // An RF notice carries only the sender byte.
  `UAT_ASSERT_NOW(a_rf_zero, clk, rst_n, out_valid && out_kind == KIND_RF, out_tdoa_us == 32'd0 && out_orient_us == 32'd0 && out_status == ST_OK)

  // A timeout carries no timing.
  `UAT_ASSERT_NOW(a_timeout_zero, clk, rst_n, out_valid && out_status == ST_TIMEOUT, out_kind == KIND_US && out_tdoa_us == 32'd0 && out_orient_us == 32'd0)

  // Input back-pressure only comes from a stalled result.
  `UAT_ASSERT_NOW(a_stall_source, clk, rst_n, in_stall, out_valid && out_stall)

  // A stalled result holds.
  `UAT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_kind) && $stable(out_node_id) && $stable(out_tdoa_us) && $stable(out_orient_us) && $stable(out_status))

endmodule

bind ultrasound_arrival_timer uat_checker u_uat_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_kind     (out_kind),
  .out_node_id  (out_node_id),
  .out_tdoa_us  (out_tdoa_us),
  .out_orient_us(out_orient_us),
  .out_status   (out_status)
);
